// File: hdl/cstt_pkg.sv
// Package for the child supervision tick table.
// Holds the shared constants, command and result word types.
// No dependencies.
package cstt_pkg;

  // Default table size and the fixed field widths.
  localparam int MAX_CHILDREN_DEF = 32;
  localparam int IDX_FIELD_W      = 5;
  localparam int INTERVAL_W       = 16;
  localparam int ADDR_LIMIT       = 1 << IDX_FIELD_W;

  // Queue depths between the parts.
  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 4;

  // Input mode codes.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_SENT  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // Classified command kinds.
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_SENT,
    CMD_WRITE
  } cmd_kind_t;

  // Command word from front to back.
  typedef struct packed {
    cmd_kind_t               kind;
    logic [IDX_FIELD_W-1:0]  index;
    logic                    valid;
    logic                    rx_always_on;
    logic [INTERVAL_W-1:0]   interval;
    logic                    has_pending;
  } cmd_t;

  // Result word from back to output queue.
  typedef struct packed {
    logic [IDX_FIELD_W-1:0] target_index;
    logic                   send_request;
    logic                   last;
  } res_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DONE
  } back_state_t;

endpackage

// File: hdl/cstt_fifo.sv
// Small register queue used between front and back and at the output.
// Depends on nothing; width and depth come from the instantiating module.
module cstt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/cstt_front.sv
// Front end: holds the enable register and classifies each input word.
// Depends on cstt_pkg.
module cstt_front import cstt_pkg::*; #(
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic [1:0]             in_mode,
  input  logic [IDX_FIELD_W-1:0] in_child_index,
  input  logic                   in_child_valid,
  input  logic                   in_rx_always_on,
  input  logic [INTERVAL_W-1:0]  in_supervision_interval,
  input  logic                   in_has_pending,
  output cmd_t                   cmd
);

  logic enable_r;
  logic in_range;

  // Supervisor enable, set out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      enable_r <= cfg_wr_data;
    end
  end

  assign in_range = (int'(in_child_index) < MAX_CHILDREN);

  // Classify: disabled ticks, bad indexes and unknown modes become no-ops
  always_comb begin
    cmd.index        = in_child_index;
    cmd.valid        = in_child_valid;
    cmd.rx_always_on = in_rx_always_on;
    cmd.interval     = in_supervision_interval;
    cmd.has_pending  = in_has_pending;
    case (in_mode)
      MODE_TICK:  cmd.kind = enable_r ? CMD_TICK : CMD_NOP;
      MODE_SENT:  cmd.kind = in_range ? CMD_SENT : CMD_NOP;
      MODE_WRITE: cmd.kind = in_range ? CMD_WRITE : CMD_NOP;
      default:    cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// File: hdl/cstt_back.sv
// Back end: child table and the sequencer that walks it on a tick.
// Depends on cstt_pkg.
module cstt_back import cstt_pkg::*; #(
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  // The table holds at most ADDR_LIMIT entries, as far as the index field reaches.
  localparam int TABLE_DEPTH = (MAX_CHILDREN < ADDR_LIMIT) ? MAX_CHILDREN : ADDR_LIMIT;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Child table
  logic                  valid_r   [TABLE_DEPTH];
  logic                  rx_r      [TABLE_DEPTH];
  logic                  pend_r    [TABLE_DEPTH];
  logic [INTERVAL_W-1:0] intv_r    [TABLE_DEPTH];
  logic [INTERVAL_W-1:0] units_r   [TABLE_DEPTH];

  back_state_t            state_r, state_nxt;
  logic [IDX_W-1:0]       walk_idx_r;
  logic [IDX_FIELD_W-1:0] held_r;
  logic                   held_vld_r;

  logic [IDX_W-1:0]      cmd_idx;
  logic [INTERVAL_W-1:0] units_inc;
  logic                  due;
  logic                  walk_end;
  logic                  start_walk, step, clr_units, wr_attr;

  assign cmd_idx  = cmd.index[IDX_W-1:0];
  assign walk_end = (walk_idx_r == IDX_W'(TABLE_DEPTH - 1));

  // Entry under the walk pointer: saturating raise and due check
  always_comb begin
    units_inc = (units_r[walk_idx_r] == '1) ? units_r[walk_idx_r]
                                            : units_r[walk_idx_r] + 1'b1;
    due = valid_r[walk_idx_r] && !rx_r[walk_idx_r] && (intv_r[walk_idx_r] != '0) &&
          (units_inc >= intv_r[walk_idx_r]) && !pend_r[walk_idx_r];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty && !res_full && cmd.kind == CMD_TICK) state_nxt = BK_WALK;
      end
      BK_WALK: begin
        if (!res_full && walk_end) state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!res_full) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs and table strobes
  always_comb begin
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res        = '0;
    res.last   = 1'b1;
    start_walk = 1'b0;
    step       = 1'b0;
    clr_units  = 1'b0;
    wr_attr    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_TICK:  start_walk = 1'b1;
            CMD_SENT: begin
              clr_units = 1'b1;
              res_push  = 1'b1;
            end
            CMD_WRITE: begin
              wr_attr  = 1'b1;
              res_push = 1'b1;
            end
            default:   res_push = 1'b1;
          endcase
        end
      end
      BK_WALK: begin
        // a newly due child releases the one held before it
        if (!res_full) begin
          step = 1'b1;
          if (due && held_vld_r) begin
            res_push         = 1'b1;
            res.target_index = held_r;
            res.send_request = 1'b1;
            res.last         = 1'b0;
          end
        end
      end
      BK_DONE: begin
        // final word: held request, or the empty word
        if (!res_full) begin
          res_push = 1'b1;
          if (held_vld_r) begin
            res.target_index = held_r;
            res.send_request = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      held_vld_r <= 1'b0;
      walk_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (start_walk) begin
        walk_idx_r <= '0;
        held_vld_r <= 1'b0;
      end else if (step) begin
        walk_idx_r <= walk_idx_r + 1'b1;
        if (due) held_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && due) begin
      held_r <= IDX_FIELD_W'(walk_idx_r);
    end
  end

  // Table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        valid_r[i] <= 1'b0;
        rx_r[i]    <= 1'b0;
        pend_r[i]  <= 1'b0;
        intv_r[i]  <= '0;
        units_r[i] <= '0;
      end
    end else begin
      if (step && valid_r[walk_idx_r] && !rx_r[walk_idx_r] && intv_r[walk_idx_r] != '0) begin
        units_r[walk_idx_r] <= units_inc;
      end
      if (clr_units) begin
        units_r[cmd_idx] <= '0;
      end
      if (wr_attr) begin
        valid_r[cmd_idx] <= cmd.valid;
        rx_r[cmd_idx]    <= cmd.rx_always_on;
        pend_r[cmd_idx]  <= cmd.has_pending;
        intv_r[cmd_idx]  <= cmd.interval;
      end
    end
  end

endmodule

// File: hdl/child_supervision_tick_table.sv
// Top level of the child supervision tick table.
// Depends on cstt_pkg, cstt_front, cstt_fifo and cstt_back.
//
// A tick occupies the back end while it takes the command, walks every table entry
// and writes the closing word; TABLE_DEPTH is MAX_CHILDREN capped at 32. The walk
// reads and updates one child a cycle while the result queue has room. Frame-sent,
// write, disabled-tick and unknown words each give one result word when taken. The
// front keeps accepting words into a two-word command queue while the back walks,
// until that queue is full, and a four-word result queue lets results wait to be
// popped; the back pauses while that queue is full.
module child_supervision_tick_table import cstt_pkg::*; #(
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [1:0]             in_mode,
  input  logic [IDX_FIELD_W-1:0] in_child_index,
  input  logic                   in_child_valid,
  input  logic                   in_rx_always_on,
  input  logic [INTERVAL_W-1:0]  in_supervision_interval,
  input  logic                   in_has_pending,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [IDX_FIELD_W-1:0] out_target_index,
  output logic                   out_send_request,
  output logic                   out_last
);

  cmd_t cmd_in, cmd_q;
  logic cmd_empty, cmd_pop;
  res_t res_in, res_q;
  logic res_full, res_push;

  // Classification
  cstt_front #(.MAX_CHILDREN(MAX_CHILDREN)) u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_mode                (in_mode),
    .in_child_index         (in_child_index),
    .in_child_valid         (in_child_valid),
    .in_rx_always_on        (in_rx_always_on),
    .in_supervision_interval(in_supervision_interval),
    .in_has_pending         (in_has_pending),
    .cmd                    (cmd_in)
  );

  // Command queue between front and back
  cstt_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_Q_DEPTH)) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_data(cmd_in),
    .full     (in_full),
    .pop      (cmd_pop),
    .pop_data (cmd_q),
    .empty    (cmd_empty)
  );

  // Table and walk
  cstt_back #(.MAX_CHILDREN(MAX_CHILDREN)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd_q),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  // Result queue
  cstt_fifo #(.WIDTH($bits(res_t)), .DEPTH(RES_Q_DEPTH)) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_in),
    .full     (res_full),
    .pop      (out_pop),
    .pop_data (res_q),
    .empty    (out_empty)
  );

  assign out_target_index = res_q.target_index;
  assign out_send_request = res_q.send_request;
  assign out_last         = res_q.last;

endmodule

// File: hdl/cstt_checker.sv
// Port-level checker for the child supervision tick table, with its bind.
// Depends on the top level's port list only.
module cstt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [4:0]  out_target_index,
  input logic        out_send_request,
  input logic        out_last
);

  // Reset leaves no result words behind
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // Reset leaves room for input words
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  // An empty word names child 0 and closes its item
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_send_request) |-> (out_target_index == 5'd0 && out_last))
    else $error("malformed empty result word");

  // A waiting result word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_target_index) && $stable(out_send_request) &&
       $stable(out_last)))
    else $error("result word changed before pop");

endmodule

bind child_supervision_tick_table cstt_checker u_cstt_checker (.*);
